### rtl/core/efmdpll_pkg.sv
// ----------------------------------------------------------------------------
// efmdpll_pkg
// shared types and constants of the run length clock recovery block
// ----------------------------------------------------------------------------
package efmdpll_pkg;

    localparam int TIME_FRAC_BITS_DEF = 24;
    localparam int DELTA_INT_BITS_DEF = 10;

    localparam int DELTA_W  = 26;
    localparam int PERIOD_W = 34;
    localparam int STEP_W   = 24;
    localparam int LEN_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int TREND_W  = 3;

    // edge error range is +-2^45
    localparam int EDGE_W   = 47;
    localparam int MAG_W    = 46;
    localparam int EDGE_LIM_BIT = 45;

    // round(0.005 * 2^24)
    localparam int GAIN_W      = 17;
    localparam int PHASE_SHIFT = 24;
    localparam logic [GAIN_W-1:0] PHASE_GAIN = 17'd83886;

    localparam logic [COUNT_W-1:0] MAX_RESULTS  = 5'd16;
    localparam logic [LEN_W-1:0]   LEN_ONE      = 4'd1;
    localparam logic [LEN_W-1:0]   LEN_MIN_EDGE = 4'd3;
    localparam logic [LEN_W-1:0]   LEN_MAX      = 4'd11;

    localparam logic [PERIOD_W-1:0] NOMINAL_PERIOD_DEF = 34'd155279895;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_DEF     = 34'd139751906;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_DEF     = 34'd170807885;
    localparam logic [STEP_W-1:0]   PERIOD_STEP_DEF    = 24'd15528;

    typedef enum logic [1:0] {
        REG_NOMINAL_PERIOD = 2'd0,
        REG_MIN_PERIOD     = 2'd1,
        REG_MAX_PERIOD     = 2'd2,
        REG_PERIOD_STEP    = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_TEST,
        ST_EDGE,
        ST_MUL,
        ST_PHASE,
        ST_DIV,
        ST_APPLY,
        ST_EMIT,
        ST_FINISH
    } state_t;

endpackage

### rtl/core/efmdpll_muldiv.sv
// ----------------------------------------------------------------------------
// efmdpll_muldiv
// scaled quotient a*b/den, one quotient bit per cycle, needs a*b < den*2^A_W
// ----------------------------------------------------------------------------
module efmdpll_muldiv #(
    parameter int A_W = efmdpll_pkg::STEP_W,
    parameter int B_W = efmdpll_pkg::PERIOD_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    input  logic [B_W-1:0] den,
    output logic           done,
    output logic [A_W-1:0] quotient
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(A_W);

    logic [P_W-1:0]   prod;
    logic [B_W:0]     trial;
    logic [B_W:0]     diff;
    logic             ge;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [B_W-1:0]   rem_reg;
    logic [A_W-1:0]   q_reg;

    assign prod  = P_W'(a) * P_W'(b);
    assign trial = {rem_reg, q_reg[A_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(A_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= prod[P_W-1:A_W];
            q_reg   <= prod[A_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[B_W-1:0] : trial[B_W-1:0];
            q_reg   <= {q_reg[A_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/core/efm_run_length_dpll.sv
// ----------------------------------------------------------------------------
// efm_run_length_dpll
// bit clock recovery from zero crossing intervals, one run length per edge
// ----------------------------------------------------------------------------
// one item in flight: after the accept state, each bit period is an advance
// (wide add) then a compare, each accepted edge passes edge, multiply and phase
// states, then for a period correction a full step or the shift-subtract divider
// before the apply state, then emit; finish closes the item; output stalls hold both
// reset is asynchronous: state, configuration and loop registers take their reset values
// at once (working values excepted), no clearing pass
// ----------------------------------------------------------------------------
module efm_run_length_dpll #(
    parameter int TIME_FRAC_BITS = efmdpll_pkg::TIME_FRAC_BITS_DEF,
    parameter int DELTA_INT_BITS = efmdpll_pkg::DELTA_INT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [33:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_delta[25:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // run_length[3:0]
    output logic        m_axis_tlast
);

    localparam int PW  = efmdpll_pkg::PERIOD_W;
    localparam int SW  = efmdpll_pkg::STEP_W;
    localparam int LW  = efmdpll_pkg::LEN_W;
    localparam int NW  = efmdpll_pkg::COUNT_W;
    localparam int TRW = efmdpll_pkg::TREND_W;
    localparam int EW  = efmdpll_pkg::EDGE_W;
    localparam int MW  = efmdpll_pkg::MAG_W;
    localparam int GW  = efmdpll_pkg::GAIN_W;
    localparam int XW  = MW + GW;
    localparam int SH  = efmdpll_pkg::PHASE_SHIFT;

    localparam int TW    = TIME_FRAC_BITS + 11;
    localparam int DFRAC = efmdpll_pkg::DELTA_W - DELTA_INT_BITS;
    localparam int SHL   = (TIME_FRAC_BITS >= DFRAC) ? TIME_FRAC_BITS - DFRAC : 0;
    localparam int SHR   = (TIME_FRAC_BITS >= DFRAC) ? 0 : DFRAC - TIME_FRAC_BITS;
    localparam int DW    = efmdpll_pkg::DELTA_W + SHL - SHR;
    localparam int CW_A  = (DW + 1 > TW) ? DW + 1 : TW;
    localparam int CW_B  = (CW_A > EW) ? CW_A : EW;
    localparam int CW    = CW_B + 2;

    localparam logic signed [CW-1:0] TIME_MAX = {{(CW-TW+1){1'b0}}, {(TW-1){1'b1}}};
    localparam logic signed [CW-1:0] TIME_MIN = ~TIME_MAX;
    localparam logic signed [CW-1:0] EDGE_MAX =
        {{(CW-efmdpll_pkg::EDGE_LIM_BIT-1){1'b0}}, 1'b1, {efmdpll_pkg::EDGE_LIM_BIT{1'b0}}};
    localparam logic signed [CW-1:0] EDGE_MIN = -EDGE_MAX;

    function automatic logic signed [TW-1:0] sat_time(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = v;
        if (v > TIME_MAX)
            r = TIME_MAX;
        else if (v < TIME_MIN)
            r = TIME_MIN;
        return r[TW-1:0];
    endfunction

    efmdpll_pkg::state_t state_reg, state_next;

    // configuration
    logic [PW-1:0] min_reg;
    logic [PW-1:0] max_reg;
    logic [SW-1:0] step_reg;

    // loop state
    logic signed [TW-1:0]  ct_reg;
    logic [PW-1:0]         bp_reg;
    logic signed [TW-1:0]  po_reg;
    logic signed [TRW-1:0] trend_reg;
    logic [LW-1:0]         pc_reg;
    logic [NW-1:0]         n_reg;
    logic                  pend_valid_reg;
    logic                  out_valid_reg;

    // working values
    logic [DW-1:0]        d_reg;
    logic signed [EW-1:0] e_reg;
    logic [MW-1:0]        mag_reg;
    logic [XW-1:0]        prod_reg;
    logic [SW-1:0]        adj_reg;
    logic [LW-1:0]        pend_len_reg;
    logic [LW-1:0]        out_len_reg;
    logic                 out_last_reg;

    logic signed [CW-1:0] d_s, ct_s, bp_s, po_s, hbp_s, min_s, max_s, adj_s;
    logic signed [CW-1:0] adv_sum, edge_raw, edge_clamped, ph_s, np_raw, np_clamped;
    logic [CW-1:0]        delta_ext;
    logic [XW:0]          rnd_sum;
    logic signed [EW-1:0] e_abs;
    logic                 e_neg, e_zero;
    logic                 more_periods;
    logic                 period_adjust;
    logic                 direct_step;
    logic                 slot_free;
    logic                 cfg_write;

    logic                 in_ready;
    logic                 div_start;
    logic                 load_out;
    logic                 div_done;
    logic [SW-1:0]        div_q;

    assign d_s   = signed'(CW'(d_reg));
    assign ct_s  = CW'(ct_reg);
    assign po_s  = CW'(po_reg);
    assign bp_s  = signed'(CW'(bp_reg));
    assign hbp_s = signed'(CW'(bp_reg >> 1));
    assign min_s = signed'(CW'(min_reg));
    assign max_s = signed'(CW'(max_reg));
    assign adj_s = signed'(CW'(adj_reg));

    assign delta_ext = CW'(s_axis_tdata[efmdpll_pkg::DELTA_W-1:0]);
    assign adv_sum   = ct_s + bp_s + po_s;
    assign edge_raw  = d_s - ct_s + hbp_s;

    always_comb
    begin
        edge_clamped = edge_raw;
        if (edge_raw > EDGE_MAX)
            edge_clamped = EDGE_MAX;
        else if (edge_raw < EDGE_MIN)
            edge_clamped = EDGE_MIN;
    end

    assign more_periods = ((d_s > ct_s) || (pc_reg < efmdpll_pkg::LEN_MIN_EDGE))
                          && (pc_reg < efmdpll_pkg::LEN_MAX);

    assign e_neg  = e_reg[EW-1];
    assign e_zero = (e_reg == '0);
    assign e_abs  = e_neg ? -e_reg : e_reg;

    // rounded phase correction, magnitude then sign
    assign rnd_sum = (XW+1)'(prod_reg) + ((XW+1)'(1) << (SH - 1));
    assign ph_s    = e_neg ? -signed'(CW'(rnd_sum[XW:SH])) : signed'(CW'(rnd_sum[XW:SH]));

    assign period_adjust = (trend_reg > 3'sd1) || (trend_reg < -3'sd1);
    assign direct_step   = (bp_reg == '0) || (mag_reg >= MW'(bp_reg));

    assign np_raw = e_neg ? bp_s - adj_s : bp_s + adj_s;

    always_comb
    begin
        np_clamped = np_raw;
        if (np_raw < min_s)
            np_clamped = min_s;
        else if (np_raw > max_s)
            np_clamped = max_s;
    end

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign cfg_write = cfg_valid && cfg_ready;

    efmdpll_muldiv #(
        .A_W (SW),
        .B_W (PW)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .a        (step_reg),
        .b        (mag_reg[PW-1:0]),
        .den      (bp_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            efmdpll_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = efmdpll_pkg::ST_ADV;
            end
            efmdpll_pkg::ST_ADV:
            begin
                if ((n_reg == efmdpll_pkg::MAX_RESULTS) || (d_s < ct_s))
                    state_next = efmdpll_pkg::ST_FINISH;
                else
                    state_next = efmdpll_pkg::ST_TEST;
            end
            efmdpll_pkg::ST_TEST:
            begin
                if (more_periods)
                    state_next = efmdpll_pkg::ST_ADV;
                else
                    state_next = efmdpll_pkg::ST_EDGE;
            end
            efmdpll_pkg::ST_EDGE:
                state_next = efmdpll_pkg::ST_MUL;
            efmdpll_pkg::ST_MUL:
                state_next = efmdpll_pkg::ST_PHASE;
            efmdpll_pkg::ST_PHASE:
            begin
                if (!period_adjust)
                    state_next = efmdpll_pkg::ST_EMIT;
                else if (direct_step)
                    state_next = efmdpll_pkg::ST_APPLY;
                else
                    state_next = efmdpll_pkg::ST_DIV;
            end
            efmdpll_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = efmdpll_pkg::ST_APPLY;
            end
            efmdpll_pkg::ST_APPLY:
                state_next = efmdpll_pkg::ST_EMIT;
            efmdpll_pkg::ST_EMIT:
            begin
                if (!pend_valid_reg || slot_free)
                    state_next = efmdpll_pkg::ST_ADV;
            end
            efmdpll_pkg::ST_FINISH:
            begin
                if (!pend_valid_reg || slot_free)
                    state_next = efmdpll_pkg::ST_IDLE;
            end
            default:
                state_next = efmdpll_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            efmdpll_pkg::ST_IDLE:
                in_ready = 1'b1;
            efmdpll_pkg::ST_PHASE:
                div_start = period_adjust && !direct_step;
            efmdpll_pkg::ST_EMIT,
            efmdpll_pkg::ST_FINISH:
                load_out = pend_valid_reg && slot_free;
            default:
            begin
                in_ready  = 1'b0;
                div_start = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= efmdpll_pkg::ST_IDLE;
            min_reg        <= efmdpll_pkg::MIN_PERIOD_DEF;
            max_reg        <= efmdpll_pkg::MAX_PERIOD_DEF;
            step_reg       <= efmdpll_pkg::PERIOD_STEP_DEF;
            ct_reg         <= '0;
            bp_reg         <= efmdpll_pkg::NOMINAL_PERIOD_DEF;
            po_reg         <= '0;
            trend_reg      <= '0;
            pc_reg         <= efmdpll_pkg::LEN_ONE;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                unique case (efmdpll_pkg::reg_index_t'(cfg_index))
                    efmdpll_pkg::REG_NOMINAL_PERIOD:
                        bp_reg <= cfg_data;
                    efmdpll_pkg::REG_MIN_PERIOD:
                        min_reg <= cfg_data;
                    efmdpll_pkg::REG_MAX_PERIOD:
                        max_reg <= cfg_data;
                    efmdpll_pkg::REG_PERIOD_STEP:
                        step_reg <= cfg_data[SW-1:0];
                    default:
                        step_reg <= step_reg;
                endcase
            end

            case (state_reg)
                efmdpll_pkg::ST_IDLE:
                begin
                    if (s_axis_tvalid)
                        n_reg <= '0;
                end
                efmdpll_pkg::ST_ADV:
                begin
                    if (!((n_reg == efmdpll_pkg::MAX_RESULTS) || (d_s < ct_s)))
                        ct_reg <= sat_time(adv_sum);
                end
                efmdpll_pkg::ST_TEST:
                begin
                    if (more_periods)
                    begin
                        po_reg <= '0;
                        pc_reg <= pc_reg + LW'(1);
                    end
                end
                efmdpll_pkg::ST_EDGE:
                begin
                    if (e_neg)
                        trend_reg <= (trend_reg < 0) ?
                                     ((trend_reg > -3'sd3) ? trend_reg - 3'sd1 : -3'sd3) :
                                     -3'sd1;
                    else if (!e_zero)
                        trend_reg <= (trend_reg > 0) ?
                                     ((trend_reg < 3'sd3) ? trend_reg + 3'sd1 : 3'sd3) :
                                     3'sd1;
                    else
                        trend_reg <= '0;
                end
                efmdpll_pkg::ST_PHASE:
                    po_reg <= sat_time(ph_s);
                efmdpll_pkg::ST_APPLY:
                    bp_reg <= np_clamped[PW-1:0];
                efmdpll_pkg::ST_EMIT:
                begin
                    if (!pend_valid_reg || slot_free)
                    begin
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + NW'(1);
                        pc_reg         <= efmdpll_pkg::LEN_ONE;
                    end
                end
                efmdpll_pkg::ST_FINISH:
                begin
                    if (!pend_valid_reg || slot_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        ct_reg         <= sat_time(ct_s - d_s);
                    end
                end
                default:
                    n_reg <= n_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_len_reg  <= pend_len_reg;
            out_last_reg <= (state_reg == efmdpll_pkg::ST_FINISH);
        end

        case (state_reg)
            efmdpll_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    d_reg <= DW'((delta_ext << SHL) >> SHR);
            end
            efmdpll_pkg::ST_TEST:
                e_reg <= edge_clamped[EW-1:0];
            efmdpll_pkg::ST_EDGE:
                mag_reg <= MW'(e_abs);
            efmdpll_pkg::ST_MUL:
                prod_reg <= XW'(mag_reg) * XW'(efmdpll_pkg::PHASE_GAIN);
            efmdpll_pkg::ST_PHASE:
                adj_reg <= step_reg;
            efmdpll_pkg::ST_DIV:
            begin
                if (div_done)
                    adj_reg <= div_q;
            end
            efmdpll_pkg::ST_EMIT:
            begin
                if (!pend_valid_reg || slot_free)
                    pend_len_reg <= pc_reg;
            end
            default:
                adj_reg <= adj_reg;
        endcase
    end

    // registers change only between items
    assign cfg_ready     = (state_reg == efmdpll_pkg::ST_IDLE) && !s_axis_tvalid;
    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8-LW){1'b0}}, out_len_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the run length clock recovery block against a cycle-free predictor
// of its bit clock, phase nudge and period correction, using directed edge
// cases, several register settings and random crossing intervals with random
// gaps and stalls on both streams
// ----------------------------------------------------------------------------
module tb;

    import efmdpll_pkg::*;

    localparam int     MAX_RUNS     = int'(MAX_RESULTS);
    localparam int     DELTA_SHIFT  = TIME_FRAC_BITS_DEF - (DELTA_W - DELTA_INT_BITS_DEF);
    localparam longint TIME_LIM     = longint'(1) <<< (TIME_FRAC_BITS_DEF + 10);
    localparam longint EDGE_LIMIT   = longint'(1) <<< EDGE_LIM_BIT;
    localparam longint NUDGE_GAIN   = 83886;
    localparam int     SETTLE_WAIT  = 100;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     CYCLE_LIMIT  = 1500000;

    typedef struct packed {
        logic [LEN_W-1:0] run_length;
        logic             last;
    } run_item_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [33:0] cfg_data = 34'd0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;   // sample_delta[25:0]

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // run_length[3:0]
    logic        m_axis_tlast;

    run_item_t expected_runs[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        sender_idle = 1'b0;
    bit        receiver_idle = 1'b0;
    bit        hold_request = 1'b0;

    // predictor state and register copies
    logic [PERIOD_W-1:0] reg_nominal;
    logic [PERIOD_W-1:0] reg_min;
    logic [PERIOD_W-1:0] reg_max;
    logic [STEP_W-1:0]   reg_step;
    longint              pll_time;
    logic [PERIOD_W-1:0] pll_period;
    longint              pll_phase;
    int                  pll_trend;
    logic [LEN_W-1:0]    pll_count;

    efm_run_length_dpll DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint sat_time(input longint v);
        if (v > TIME_LIM - 1)
            return TIME_LIM - 1;
        if (v < -TIME_LIM)
            return -TIME_LIM;
        return v;
    endfunction

    task automatic correct_period(input longint err);
        longint mag;
        longint adj;
        longint np;
        mag = err < 0 ? -err : err;
        if (pll_period == '0 || mag >= longint'(pll_period))
            adj = longint'(reg_step);
        else
            adj = (longint'(reg_step) * mag) / longint'(pll_period);
        np = err < 0 ? longint'(pll_period) - adj : longint'(pll_period) + adj;
        if (np < longint'(reg_min))
            np = longint'(reg_min);
        else if (np > longint'(reg_max))
            np = longint'(reg_max);
        pll_period = PERIOD_W'(np);
    endtask

    task automatic predict_run_lengths(input logic [DELTA_W-1:0] delta);
        longint           d;
        longint           nxt;
        longint           err;
        longint           mag;
        longint           nudge;
        logic [LEN_W-1:0] lens [0:MAX_RUNS-1];
        run_item_t        item;
        int               n;
        d = longint'(delta) <<< DELTA_SHIFT;
        n = 0;
        while (n < MAX_RUNS && d >= pll_time)
        begin
            nxt = sat_time(pll_time + longint'(pll_period) + pll_phase);
            pll_time = nxt;
            if ((d > nxt || pll_count < LEN_MIN_EDGE) && pll_count < LEN_MAX)
            begin
                pll_phase = 0;
                pll_count = pll_count + 1'b1;
            end
            else
            begin
                err = d - (nxt - longint'(pll_period >> 1));
                if (err > EDGE_LIMIT)
                    err = EDGE_LIMIT;
                if (err < -EDGE_LIMIT)
                    err = -EDGE_LIMIT;
                mag = err < 0 ? -err : err;
                nudge = (mag * NUDGE_GAIN + (longint'(1) <<< (PHASE_SHIFT - 1))) >>> PHASE_SHIFT;
                pll_phase = sat_time(err < 0 ? -nudge : nudge);
                if (err < 0)
                    pll_trend = pll_trend < 0 ? (pll_trend > -3 ? pll_trend - 1 : -3) : -1;
                else if (err > 0)
                    pll_trend = pll_trend > 0 ? (pll_trend < 3 ? pll_trend + 1 : 3) : 1;
                else
                    pll_trend = 0;
                if (pll_trend < -1 || pll_trend > 1)
                    correct_period(err);
                lens[n] = pll_count;
                n++;
                pll_count = LEN_ONE;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            item.run_length = lens[i];
            item.last = (i == n - 1);
            expected_runs.insert(expected_runs.size(), item);
        end
        pll_time = sat_time(pll_time - d);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("tb: mismatch on %s, expected %0d, got %0d, cycle %0d",
                 what, want, got, cycle_count);
        mismatch_count++;
    endtask

    // result checker
    initial
    begin
        run_item_t want;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_runs.size() == 0)
                    report_mismatch("unexpected run length", 0, int'(m_axis_tdata[LEN_W-1:0]));
                else
                begin
                    want = expected_runs.pop_front();
                    if (m_axis_tdata[LEN_W-1:0] !== want.run_length)
                        report_mismatch("run_length", int'(want.run_length),
                                        int'(m_axis_tdata[LEN_W-1:0]));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", int'(want.last), int'(m_axis_tlast));
                end
            end
        end
    end

    // receiver: random stalls, and one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (receiver_idle && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [PERIOD_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_NOMINAL_PERIOD:
            begin
                reg_nominal = value;
                pll_period = value;
            end
            REG_MIN_PERIOD:  reg_min = value;
            REG_MAX_PERIOD:  reg_max = value;
            REG_PERIOD_STEP: reg_step = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_periods(input logic [PERIOD_W-1:0] nominal, input logic [PERIOD_W-1:0] lo,
                               input logic [PERIOD_W-1:0] hi, input logic [STEP_W-1:0] step,
                               input bit load_nominal);
        write_reg(REG_MIN_PERIOD, lo);
        write_reg(REG_MAX_PERIOD, hi);
        write_reg(REG_PERIOD_STEP, PERIOD_W'(step));
        if (load_nominal)
            write_reg(REG_NOMINAL_PERIOD, nominal);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_delta(input logic [DELTA_W-1:0] delta);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tdata <= {{(32 - DELTA_W){1'b0}}, delta};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predict_run_lengths(delta);
    endtask

    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_runs.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // crossing interval of t bit periods, stretched by skew per period, plus jitter
    function automatic logic [DELTA_W-1:0] run_delta(input int t, input longint skew,
                                                     input longint jitter_max);
        longint p;
        longint v;
        longint jit;
        p = longint'(pll_period >> DELTA_SHIFT);
        jit = jitter_max > 0 ? longint'($urandom_range(0, int'(jitter_max))) : 0;
        if ($urandom_range(0, 1) == 0)
            jit = -jit;
        v = longint'(t) * (p + skew) + jit;
        if (v < 0)
            v = 0;
        if (v > (longint'(1) <<< DELTA_W) - 1)
            v = (longint'(1) <<< DELTA_W) - 1;
        return DELTA_W'(v);
    endfunction

    function automatic logic [DELTA_W-1:0] random_delta(input longint skew);
        longint p;
        int     k;
        p = longint'(pll_period >> DELTA_SHIFT);
        k = $urandom_range(0, 99);
        if (k < 85)
            return run_delta($urandom_range(3, 11), skew, p / 5);
        if (k < 93)
            return DELTA_W'($urandom);
        return run_delta($urandom_range(0, 2), skew, p / 3);
    endfunction

    task automatic test_directed();
        longint p;
        p = longint'(pll_period >> DELTA_SHIFT);
        send_delta('0);
        for (int t = 3; t <= 11; t++)
            send_delta(run_delta(t, 0, 0));
        // too early to count as an edge
        send_delta(run_delta(2, 0, 0));
        // same-sign errors in a row correct the period both ways
        send_delta(run_delta(4, p / 10, 0));
        send_delta(run_delta(5, p / 10, 0));
        send_delta(run_delta(4, -p / 10, 0));
        send_delta(run_delta(5, -p / 10, 0));
        send_delta('1);
        send_delta(DELTA_W'(1));
        wait_until_idle();
    endtask

    // zero period: forced runs every loop, result overflow, correction from zero
    task automatic test_period_zero();
        set_periods('0, '0, '1, '1, 1'b1);
        send_delta(DELTA_W'(1000));
        send_delta(DELTA_W'(5000));
        send_delta('1);
        wait_until_idle();
    endtask

    // widest period saturates the clock; min above max on the clamp
    task automatic test_wide_range();
        set_periods('1, '1, '0, '0, 1'b1);
        send_delta('1);
        send_delta('0);
        send_delta(DELTA_W'(12345));
        send_delta('1);
        wait_until_idle();
    endtask

    task automatic test_random_configs();
        longint nom;
        longint lo;
        longint hi;
        longint step;
        longint skew;
        for (int ph = 0; ph < 6; ph++)
        begin
            nom = longint'(NOMINAL_PERIOD_DEF) * $urandom_range(90, 110) / 100;
            lo = nom * $urandom_range(85, 97) / 100;
            hi = nom * $urandom_range(103, 115) / 100;
            step = longint'($urandom_range(0, 4 * int'(PERIOD_STEP_DEF)));
            if (ph == 1)
                step = 0;
            if (ph == 2)
                step = longint'(STEP_W'('1));
            if (ph == 3)
            begin
                lo = nom * 105 / 100;
                hi = nom * 95 / 100;
            end
            if (ph == 4)
            begin
                lo = 0;
                hi = longint'(PERIOD_W'('1));
            end
            set_periods(PERIOD_W'(nom), PERIOD_W'(lo), PERIOD_W'(hi), STEP_W'(step), ph != 5);
            sender_idle = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            skew = longint'($urandom_range(0, 2 * int'(nom >> DELTA_SHIFT) / 25))
                   - (nom >> DELTA_SHIFT) / 25;
            for (int i = 0; i < 35; i++)
                send_delta(random_delta(skew));
            wait_until_idle();
        end
    endtask

    // receiver holds off long while items keep coming
    task automatic test_backpressure();
        set_periods(NOMINAL_PERIOD_DEF, MIN_PERIOD_DEF, MAX_PERIOD_DEF, PERIOD_STEP_DEF, 1'b1);
        sender_idle = 1'b0;
        receiver_idle = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 20; i++)
            send_delta(random_delta(0));
        wait_until_idle();
    endtask

    // sender pauses at random, and waits for all run lengths to drain between two batches
    task automatic test_sender_pause();
        sender_idle = 1'b1;
        for (int i = 0; i < 10; i++)
            send_delta(random_delta(0));
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_runs.size() != 0);
        for (int i = 0; i < 10; i++)
            send_delta(random_delta(0));
        wait_until_idle();
    endtask

    task automatic test_steady_stream();
        sender_idle = 1'b0;
        receiver_idle = 1'b0;
        for (int i = 0; i < 40; i++)
            send_delta(random_delta(0));
    endtask

    initial
    begin
        reg_nominal = NOMINAL_PERIOD_DEF;
        reg_min = MIN_PERIOD_DEF;
        reg_max = MAX_PERIOD_DEF;
        reg_step = PERIOD_STEP_DEF;
        pll_time = 0;
        pll_period = NOMINAL_PERIOD_DEF;
        pll_phase = 0;
        pll_trend = 0;
        pll_count = LEN_ONE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_period_zero();
        test_wide_range();
        test_random_configs();
        test_backpressure();
        test_sender_pause();
        test_steady_stream();

        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_runs.size() != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
